[rtl/gds_pkg.sv]
package gds_pkg;

    // Operation codes carried in the input tuser field.
    localparam logic [1:0] FUNC_SPLAT = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] CFG_SPACING  = 3'd3;
    localparam logic [2:0] CFG_DIM_X    = 3'd4;
    localparam logic [2:0] CFG_DIM_Y    = 3'd5;
    localparam logic [2:0] CFG_DIM_Z    = 3'd6;

    // Datapath widths that follow from the fixed field widths.
    localparam int CW     = 27;  // signed per-axis offset, Q.8
    localparam int SQW    = 54;  // one squared offset, Q.16
    localparam int DSQW   = 56;  // sum of three squares
    localparam int LIMW   = 38;  // 64 * radius^2
    localparam int REMW   = 39;  // divider remainder after the shift
    localparam int DENS_W = 17;  // density and table entry, Q1.16

    typedef logic [DENS_W-1:0] dens_t;

endpackage

[rtl/gaussian_density_splat_top.sv]
// Gaussian density splatting onto a voxel grid held in one on-chip memory.
// Items arrive on the s_axis channel, with the operation code in tuser. A splat
// adds exp(-(dist/(2r))^2) to every voxel of the configured grid, a read returns
// one voxel clamped to 1.0 and a clear zeroes the whole store. Every item gives
// exactly one result transfer on m_axis, with the operation code echoed in tuser.
// Items are processed one at a time; s_axis_tready is high only when idle.
// A splat takes each voxel in use through square, sum, compare, a division with
// one quotient bit per cycle, table look-up and write back; a voxel out of range
// of the atom goes from the compare straight on to the next voxel. A clear writes
// one memory entry per cycle.
// After reset the block sweeps all DIM_MAX^3 memory entries to zero before it
// takes the first item; configuration writes on cfg_we are accepted at any time
// but must only be issued while the block is idle. If m_axis_tready is low the
// result waits in the output register; the block still takes the next item and
// holds in its final state once that item's result is ready.
module gaussian_density_splat_top #(
    parameter int DIM_MAX        = 32,
    parameter int ACC_WIDTH      = 24,
    parameter int EXP_TABLE_SIZE = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // atom_x, atom_y, atom_z, atom_radius, voxel_index, zero pad
    input  logic [103:0] s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // density, zero pad
    output logic [23:0]  m_axis_tdata,
    // op_done
    output logic [1:0]   m_axis_tuser
);

    localparam int DEPTH = DIM_MAX * DIM_MAX * DIM_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int EDW   = $clog2(DIM_MAX + 1);
    localparam int LW    = $clog2(EXP_TABLE_SIZE);
    localparam int NW    = $clog2(LW) + 1;
    localparam int CW    = gds_pkg::CW;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SP_INIT, ST_SP_SQ, ST_SP_SUM, ST_SP_CMP, ST_SP_DIV,
        ST_SP_LUT, ST_SP_WR, ST_SP_NEXT, ST_RD, ST_RD_WAIT, ST_DONE
    } state_t;

    state_t state_reg;

    logic [23:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [15:0] spacing_reg;
    logic [5:0]  dim_x_reg, dim_y_reg, dim_z_reg;

    logic [1:0]  func_reg;
    logic [23:0] atom_x_reg, atom_y_reg, atom_z_reg;
    logic [15:0] radius_reg;
    logic [14:0] vidx_reg;

    logic signed [CW-1:0]       px_reg, py_reg, pz_reg;
    logic [gds_pkg::SQW-1:0]    sqx_reg, sqy_reg, sqz_reg;
    logic [gds_pkg::DSQW-1:0]   dsq_reg;
    logic [gds_pkg::LIMW-1:0]   lim_reg;
    logic [gds_pkg::REMW-1:0]   rem_reg;
    logic [LW-1:0]              e_reg;
    logic [NW-1:0]              div_cnt_reg;
    logic [EDW-1:0]             i_reg, j_reg, k_reg;
    logic [AW-1:0]              idx_reg;
    logic [AW-1:0]              clr_addr_reg;
    logic                       clr_op_reg;
    gds_pkg::dens_t             dens_reg;
    logic                       out_valid_reg;
    gds_pkg::dens_t             out_dens_reg;
    logic [1:0]                 out_op_reg;

    logic [EDW-1:0]          nx, ny, nz;
    logic [31:0]             total;
    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_waddr, mem_raddr;
    logic [ACC_WIDTH-1:0]    mem_wdata, mem_rdata;
    gds_pkg::dens_t          rom_data;
    logic [ACC_WIDTH:0]      acc_sum;
    logic [ACC_WIDTH-1:0]    acc_sat;
    logic [gds_pkg::REMW-1:0] rem_sh;
    logic                    rem_ge;
    logic signed [CW-1:0]    bx, by, bz, sp_ext;
    logic                    last_x, last_y, last_z;

    assign nx = (32'(dim_x_reg) > 32'(DIM_MAX)) ? EDW'(DIM_MAX) : EDW'(dim_x_reg);
    assign ny = (32'(dim_y_reg) > 32'(DIM_MAX)) ? EDW'(DIM_MAX) : EDW'(dim_y_reg);
    assign nz = (32'(dim_z_reg) > 32'(DIM_MAX)) ? EDW'(DIM_MAX) : EDW'(dim_z_reg);
    assign total = 32'(nx) * 32'(ny) * 32'(nz);

    assign bx = CW'($signed(origin_x_reg)) - CW'($signed(atom_x_reg));
    assign by = CW'($signed(origin_y_reg)) - CW'($signed(atom_y_reg));
    assign bz = CW'($signed(origin_z_reg)) - CW'($signed(atom_z_reg));
    assign sp_ext = CW'($signed({1'b0, spacing_reg}));

    assign last_x = (i_reg == nx - EDW'(1));
    assign last_y = (j_reg == ny - EDW'(1));
    assign last_z = (k_reg == nz - EDW'(1));

    // One restoring division step: the quotient is floor(dsq * N / lim).
    assign rem_sh = {rem_reg[gds_pkg::REMW-2:0], 1'b0};
    assign rem_ge = (rem_sh >= {1'b0, lim_reg});

    assign acc_sum = {1'b0, mem_rdata} + (ACC_WIDTH + 1)'(rom_data);
    assign acc_sat = acc_sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : acc_sum[ACC_WIDTH-1:0];

    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_SP_WR);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : idx_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : acc_sat;
    assign mem_re    = (state_reg == ST_SP_SQ) || (state_reg == ST_RD);
    assign mem_raddr = (state_reg == ST_RD) ? AW'(vidx_reg) : idx_reg;

    gds_ram #(
        .WIDTH (ACC_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    gds_exp_rom #(
        .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
    ) u_exp_rom (
        .clk  (clk),
        .addr (e_reg),
        .data (rom_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_dens_reg};
    assign m_axis_tuser  = out_op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            origin_z_reg  <= '0;
            spacing_reg   <= 16'd256;
            dim_x_reg     <= 6'd32;
            dim_y_reg     <= 6'd32;
            dim_z_reg     <= 6'd32;
            clr_addr_reg  <= '0;
            clr_op_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gds_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                    gds_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                    gds_pkg::CFG_ORIGIN_Z: origin_z_reg <= cfg_data;
                    gds_pkg::CFG_SPACING:  spacing_reg  <= cfg_data[15:0];
                    gds_pkg::CFG_DIM_X:    dim_x_reg    <= cfg_data[5:0];
                    gds_pkg::CFG_DIM_Y:    dim_y_reg    <= cfg_data[5:0];
                    gds_pkg::CFG_DIM_Z:    dim_z_reg    <= cfg_data[5:0];
                    default: ;
                endcase
            end

            // In ST_DONE the output register is reloaded below instead.
            if (out_valid_reg && m_axis_tready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_addr_reg == AW'(DEPTH - 1))
                    begin
                        clr_addr_reg <= '0;
                        state_reg    <= clr_op_reg ? ST_DONE : ST_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + AW'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        func_reg   <= s_axis_tuser;
                        atom_x_reg <= s_axis_tdata[23:0];
                        atom_y_reg <= s_axis_tdata[47:24];
                        atom_z_reg <= s_axis_tdata[71:48];
                        radius_reg <= s_axis_tdata[87:72];
                        vidx_reg   <= s_axis_tdata[102:88];
                        dens_reg   <= '0;
                        case (s_axis_tuser)
                            gds_pkg::FUNC_SPLAT: state_reg <= ST_SP_INIT;
                            gds_pkg::FUNC_READ:  state_reg <= ST_RD;
                            gds_pkg::FUNC_CLEAR:
                            begin
                                clr_op_reg <= 1'b1;
                                state_reg  <= ST_CLEAR;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_SP_INIT:
                begin
                    lim_reg <= {32'(radius_reg) * 32'(radius_reg), 6'd0};
                    px_reg  <= bx;
                    py_reg  <= by;
                    pz_reg  <= bz;
                    i_reg   <= '0;
                    j_reg   <= '0;
                    k_reg   <= '0;
                    idx_reg <= '0;
                    if (radius_reg == '0 || nx == '0 || ny == '0 || nz == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_SP_SQ;
                    end
                end
                ST_SP_SQ:
                begin
                    sqx_reg   <= gds_pkg::SQW'(px_reg * px_reg);
                    sqy_reg   <= gds_pkg::SQW'(py_reg * py_reg);
                    sqz_reg   <= gds_pkg::SQW'(pz_reg * pz_reg);
                    state_reg <= ST_SP_SUM;
                end
                ST_SP_SUM:
                begin
                    dsq_reg   <= gds_pkg::DSQW'(sqx_reg) + gds_pkg::DSQW'(sqy_reg)
                               + gds_pkg::DSQW'(sqz_reg);
                    state_reg <= ST_SP_CMP;
                end
                ST_SP_CMP:
                begin
                    if (dsq_reg >= gds_pkg::DSQW'(lim_reg))
                    begin
                        state_reg <= ST_SP_NEXT;
                    end
                    else
                    begin
                        rem_reg     <= gds_pkg::REMW'(dsq_reg);
                        e_reg       <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= ST_SP_DIV;
                    end
                end
                ST_SP_DIV:
                begin
                    rem_reg     <= rem_ge ? (rem_sh - {1'b0, lim_reg}) : rem_sh;
                    e_reg       <= {e_reg[LW-2:0], rem_ge};
                    div_cnt_reg <= div_cnt_reg + NW'(1);
                    if (div_cnt_reg == NW'(LW - 1))
                    begin
                        state_reg <= ST_SP_LUT;
                    end
                end
                ST_SP_LUT:
                begin
                    state_reg <= ST_SP_WR;
                end
                ST_SP_WR:
                begin
                    state_reg <= ST_SP_NEXT;
                end
                ST_SP_NEXT:
                begin
                    idx_reg <= idx_reg + AW'(1);
                    if (!last_x)
                    begin
                        i_reg     <= i_reg + EDW'(1);
                        px_reg    <= px_reg + sp_ext;
                        state_reg <= ST_SP_SQ;
                    end
                    else
                    begin
                        i_reg  <= '0;
                        px_reg <= bx;
                        if (!last_y)
                        begin
                            j_reg     <= j_reg + EDW'(1);
                            py_reg    <= py_reg + sp_ext;
                            state_reg <= ST_SP_SQ;
                        end
                        else
                        begin
                            j_reg  <= '0;
                            py_reg <= by;
                            if (!last_z)
                            begin
                                k_reg     <= k_reg + EDW'(1);
                                pz_reg    <= pz_reg + sp_ext;
                                state_reg <= ST_SP_SQ;
                            end
                            else
                            begin
                                state_reg <= ST_DONE;
                            end
                        end
                    end
                end
                ST_RD:
                begin
                    state_reg <= (32'(vidx_reg) < total) ? ST_RD_WAIT : ST_DONE;
                end
                ST_RD_WAIT:
                begin
                    if ({1'b0, mem_rdata} > (ACC_WIDTH + 1)'(65536))
                    begin
                        dens_reg <= gds_pkg::DENS_W'(65536);
                    end
                    else
                    begin
                        dens_reg <= gds_pkg::DENS_W'(mem_rdata);
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_dens_reg  <= dens_reg;
                        out_op_reg    <= func_reg;
                        clr_op_reg    <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/gds_ram.sv]
module gds_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/gds_exp_rom.sv]
module gds_exp_rom #(
    parameter int EXP_TABLE_SIZE = 256
) (
    input  logic                              clk,
    input  logic [$clog2(EXP_TABLE_SIZE)-1:0] addr,
    output gds_pkg::dens_t                    data
);

    // Shift-and-subtract quotient, only ever evaluated on constant table indexes.
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            q = {q[62:0], 1'b0};
            if (r >= den)
            begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry e approximates exp(-16e/N) in Q1.16: a Taylor series for exp(-e/N)
    // in Q30, squared four times with rounding.
    function automatic gds_pkg::dens_t exp_entry(input longint unsigned e);
        longint unsigned term;
        longint          sum;
        longint unsigned v;
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        for (int i = 1; i <= 20; i++)
        begin
            term = udiv(term * e, longint'(EXP_TABLE_SIZE) * longint'(i));
            if ((i & 1) == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        v = longint'(sum);
        if (v > (64'd1 << 30))
        begin
            v = 64'd1 << 30;
        end
        for (int i = 0; i < 4; i++)
        begin
            v = (v * v + (64'd1 << 29)) >> 30;
        end
        return gds_pkg::DENS_W'((v + (64'd1 << 13)) >> 14);
    endfunction

    gds_pkg::dens_t rom [EXP_TABLE_SIZE];

    for (genvar g = 0; g < EXP_TABLE_SIZE; g++)
    begin : g_rom
        assign rom[g] = exp_entry(longint'(g));
    end

    always_ff @(posedge clk)
    begin
        data <= rom[addr];
    end

endmodule
